// ===== src/gbd_pkg.sv =====
package gbd_pkg;

	// Scale mode codes held in the scale_mode register.
	localparam logic [2:0] MODE_FULL       = 3'd0;
	localparam logic [2:0] MODE_TWO_THIRDS = 3'd1;
	localparam logic [2:0] MODE_HALF       = 3'd2;
	localparam logic [2:0] MODE_THIRD      = 3'd3;
	localparam logic [2:0] MODE_QUARTER    = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SCALE_MODE   = 2'd0;
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [11:0] HEIGHT_RESET = 12'd480;

	// Reciprocal of nine in 16 fractional bits, exact for dividends below 2^15.
	localparam logic [12:0] RECIP_NINE = 13'd7282;

	// Everything the scan position decides about one pixel.
	typedef struct packed {
		logic [2:0] mode;     // effective scale mode
		logic       emit;     // pixel completes an output
		logic       eor;      // output closes an output row
		logic       eof;      // output closes the output frame
		logic       first;    // first pixel of a horizontal group
		logic       sum_wr;   // group closes, column sum is updated
		logic       band0;    // first row of a block band
		logic       line_wr;  // pixel goes into the line buffer
		logic       sh_u;     // two-thirds weights
		logic       sh_l;
		logic       sh_a;
		logic       sh_b;
	} item_info_t;

	// One result item leaving the arithmetic.
	typedef struct packed {
		logic       emit;
		logic [7:0] pixel;
		logic       eor;
		logic       eof;
	} result_t;

	// Truncated division of a 12-bit value by nine.
	function automatic logic [8:0] div9(input logic [11:0] s);
		logic [24:0] prod;
		prod = 25'(s) * 25'(RECIP_NINE);
		return prod[24:16];
	endfunction

endpackage

// ===== src/grayscale_box_downscaler_core.sv =====
// Channel   Signals                                   Direction
// pixel     px_valid, px_ready, pixel_in              into the block
// result    res_valid, res_ready, pixel_out,          out of the block
//           end_of_row, end_of_frame
// config    cfg_valid, cfg_ready, cfg_index, cfg_data into the block
//
// One pixel is taken every cycle unless a waiting result stalls input; its result
// passes the registered read of the line buffer and column-sum RAMs, which feed
// a single arithmetic stage ahead of the output register.
// Reset clears control and configuration; the RAMs need no clearing pass.
// A waiting result stalls input only when the arithmetic stage also holds a result.
module grayscale_box_downscaler_core
	import gbd_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        px_valid,
	output logic        px_ready,
	input  logic [7:0]  pixel_in,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  pixel_out,
	output logic        end_of_row,
	output logic        end_of_frame,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int SUM_DEPTH = MAX_WIDTH / 2;
	localparam int GW        = $clog2(SUM_DEPTH);

	logic [2:0]    scale_mode_q;
	logic [11:0]   image_width_q;
	logic [11:0]   image_height_q;
	logic          restart;
	logic          accept;

	item_info_t    info;
	logic [CW-1:0] col;
	logic [GW-1:0] grp;
	logic [11:0]   hsum_q;
	logic [11:0]   hsum_nxt;

	logic          valid_s1;
	item_info_t    info_s1;
	logic [7:0]    px_s1;
	logic [11:0]   hsum_s1;
	logic [GW-1:0] grp_s1;
	logic          adv_s1;

	logic [7:0]    up_rd;
	logic [11:0]   col_sum_rd;
	logic [7:0]    upper_left_q;
	logic [7:0]    left_q;
	result_t       res_s1;
	logic [11:0]   sum_wdata;

	logic          res_valid_q;
	logic [7:0]    pixel_out_q;
	logic          end_of_row_q;
	logic          end_of_frame_q;

	// Configuration writes; any register write restarts the frame.
	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && cfg_ready && (cfg_index == CFG_SCALE_MODE
	                   || cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q   <= MODE_FULL;
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCALE_MODE:   scale_mode_q   <= cfg_data[2:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Handshake: the arithmetic stage moves on unless its result finds the
	// output register full and not being taken.
	assign adv_s1   = valid_s1 && (!res_s1.emit || !res_valid_q || res_ready);
	assign px_ready = !valid_s1 || adv_s1;
	assign accept   = px_valid && px_ready;

	gbd_scan #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.scale_mode  (scale_mode_q),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.restart     (restart),
		.advance     (accept),
		.info        (info),
		.col         (col),
		.grp         (grp)
	);

	// Running sum across the pixels of one horizontal group.
	assign hsum_nxt = info.first ? 12'(pixel_in) : hsum_q + 12'(pixel_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsum_q <= '0;
		end else if (restart) begin
			hsum_q <= '0;
		end else if (accept) begin
			hsum_q <= hsum_nxt;
		end
	end

	// Line buffer: read the pixel above and store the new one in the same cycle.
	gbd_ram #(
		.WIDTH(8),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (accept && info.line_wr),
		.waddr(col),
		.wdata(pixel_in),
		.re   (accept),
		.raddr(col),
		.rdata(up_rd)
	);

	// Column sums of each block group, written back from the arithmetic stage.
	gbd_ram #(
		.WIDTH(12),
		.DEPTH(SUM_DEPTH)
	) u_sum_ram (
		.clk  (clk),
		.we   (adv_s1 && info_s1.sum_wr),
		.waddr(grp_s1),
		.wdata(sum_wdata),
		.re   (accept),
		.raddr(grp),
		.rdata(col_sum_rd)
	);

	// Arithmetic stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
			px_s1   <= pixel_in;
			hsum_s1 <= hsum_nxt;
			grp_s1  <= grp;
		end
	end

	// Neighbor pixels for the two-thirds weights, in pixel order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_left_q <= '0;
			left_q       <= '0;
		end else if (restart) begin
			upper_left_q <= '0;
			left_q       <= '0;
		end else if (adv_s1) begin
			upper_left_q <= up_rd;
			left_q       <= px_s1;
		end
	end

	gbd_calc u_calc (
		.info      (info_s1),
		.px        (px_s1),
		.up        (up_rd),
		.upper_left(upper_left_q),
		.left      (left_q),
		.hsum      (hsum_s1),
		.col_sum   (col_sum_rd),
		.res       (res_s1),
		.sum_wdata (sum_wdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && res_s1.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_s1.emit) begin
			pixel_out_q    <= res_s1.pixel;
			end_of_row_q   <= res_s1.eor;
			end_of_frame_q <= res_s1.eof;
		end
	end

	assign res_valid    = res_valid_q;
	assign pixel_out    = pixel_out_q;
	assign end_of_row   = end_of_row_q;
	assign end_of_frame = end_of_frame_q;

	a_eof_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && end_of_frame |-> end_of_row)
		else $error("frame end flagged without row end");

	a_full_mode_emits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && info_s1.mode == MODE_FULL |-> res_s1.emit)
		else $error("pass-through pixel produced no result");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_s1.emit |=> res_valid_q)
		else $error("result lost between arithmetic stage and output register");

endmodule

// ===== src/gbd_ram.sv =====
module gbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; a read at the written
	// address returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/gbd_scan.sv =====
module gbd_scan
	import gbd_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [2:0]                       scale_mode,
	input  logic [11:0]                      image_width,
	input  logic [11:0]                      image_height,
	input  logic                             restart,
	input  logic                             advance,
	output item_info_t                       info,
	output logic [$clog2(MAX_WIDTH)-1:0]     col,
	output logic [$clog2(MAX_WIDTH/2)-1:0]   grp
);

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int SUM_DEPTH = MAX_WIDTH / 2;
	localparam int GW        = $clog2(SUM_DEPTH);
	localparam int WE        = (CW + 1 > 12) ? CW + 1 : 12;

	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic [1:0]    ph_q;
	logic [1:0]    band_q;
	logic [GW:0]   grp_q;

	logic [2:0]    mode;
	logic [1:0]    blk_m1;
	logic [2:0]    blkw;
	logic [WE-1:0] w_e;
	logic [11:0]   h_e;
	logic [WE:0]   col_x;
	logic [WE:0]   wx;
	logic [12:0]   row_x;
	logic [12:0]   hx;
	logic          last_col;
	logic          last_row;
	logic          col_fit;
	logic          row_fit;
	logic          col_end;
	logic          row_end;
	logic          ph_last;
	logic          band_last;
	logic          grp_ok;

	// Effective mode, block size and frame size.
	always_comb begin
		mode = (scale_mode > MODE_QUARTER) ? MODE_QUARTER : scale_mode;
		case (mode)
			MODE_TWO_THIRDS: blk_m1 = 2'd2;
			MODE_HALF:       blk_m1 = 2'd1;
			MODE_THIRD:      blk_m1 = 2'd2;
			MODE_QUARTER:    blk_m1 = 2'd3;
			default:         blk_m1 = 2'd0;
		endcase
		blkw = {1'b0, blk_m1} + 3'd1;
		if (image_width == 12'd0) begin
			w_e = WE'(1);
		end else if (WE'(image_width) > WE'(MAX_WIDTH)) begin
			w_e = WE'(MAX_WIDTH);
		end else begin
			w_e = WE'(image_width);
		end
		h_e = (image_height == 12'd0) ? 12'd1 : image_height;
	end

	// Position tests: does the current block fit, is it the last one.
	always_comb begin
		col_x     = (WE+1)'(col_q);
		wx        = {1'b0, w_e};
		row_x     = {1'b0, row_q};
		hx        = {1'b0, h_e};
		last_col  = (col_x + (WE+1)'(1)) == wx;
		last_row  = (row_x + 13'd1) == hx;
		col_fit   = (col_x + (WE+1)'(blkw) - (WE+1)'(ph_q)) <= wx;
		row_fit   = (row_x + 13'(blkw) - 13'(band_q)) <= hx;
		col_end   = (col_x + (WE+1)'(1) + (WE+1)'(blkw)) > wx;
		row_end   = (row_x + 13'd1 + 13'(blkw)) > hx;
		ph_last   = ph_q == blk_m1;
		band_last = band_q == blk_m1;
		grp_ok    = grp_q < (GW+1)'(SUM_DEPTH);
	end

	// Per-pixel control for the datapath.
	always_comb begin
		info         = '0;
		info.mode    = mode;
		info.first   = ph_q == 2'd0;
		info.band0   = band_q == 2'd0;
		info.sh_u    = band_q == 2'd2;
		info.sh_l    = band_q == 2'd1;
		info.sh_a    = ph_q == 2'd2;
		info.sh_b    = ph_q == 2'd1;
		case (mode)
			MODE_FULL: begin
				info.emit = 1'b1;
				info.eor  = last_col;
				info.eof  = last_col && last_row;
			end
			MODE_TWO_THIRDS: begin
				info.line_wr = 1'b1;
				info.emit    = (band_q != 2'd0) && (ph_q != 2'd0) && col_fit && row_fit;
				info.eor     = ph_last && col_end;
				info.eof     = ph_last && col_end && band_last && row_end;
			end
			default: begin
				info.sum_wr = ph_last && grp_ok;
				info.emit   = ph_last && grp_ok && band_last && row_fit;
				info.eor    = ph_last && col_end;
				info.eof    = ph_last && col_end && band_last && row_end;
			end
		endcase
	end

	// Raster position and block phase counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ph_q   <= '0;
			band_q <= '0;
			grp_q  <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			ph_q   <= '0;
			band_q <= '0;
			grp_q  <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				ph_q  <= '0;
				grp_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					band_q <= '0;
				end else begin
					row_q  <= row_q + 12'd1;
					band_q <= band_last ? 2'd0 : band_q + 2'd1;
				end
			end else begin
				col_q <= col_q + CW'(1);
				ph_q  <= ph_last ? 2'd0 : ph_q + 2'd1;
				grp_q <= grp_q + (GW+1)'(ph_last);
			end
		end
	end

	assign col = col_q;
	assign grp = grp_q[GW-1:0];

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		col_x < wx)
		else $error("column position beyond frame width");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_x < hx)
		else $error("row position beyond frame height");

	a_phase_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q <= blk_m1 && band_q <= blk_m1)
		else $error("block phase beyond block size");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> col_q == '0 && row_q == '0 && ph_q == 2'd0 && band_q == 2'd0)
		else $error("frame restart did not clear the position");

endmodule

// ===== src/gbd_calc.sv =====
module gbd_calc
	import gbd_pkg::*;
(
	input  item_info_t  info,
	input  logic [7:0]  px,
	input  logic [7:0]  up,
	input  logic [7:0]  upper_left,
	input  logic [7:0]  left,
	input  logic [11:0] hsum,
	input  logic [11:0] col_sum,
	output result_t     res,
	output logic [11:0] sum_wdata
);

	logic [1:0]  sh_ul;
	logic [1:0]  sh_up;
	logic [1:0]  sh_lf;
	logic [1:0]  sh_px;
	logic [9:0]  wsum;
	logic [8:0]  q_two;
	logic [11:0] block_sum;
	logic [8:0]  q_three;

	// Two-thirds: four weighted neighbors, then times four over nine.
	always_comb begin
		sh_ul = 2'(info.sh_u) + 2'(info.sh_a);
		sh_up = 2'(info.sh_u) + 2'(info.sh_b);
		sh_lf = 2'(info.sh_l) + 2'(info.sh_a);
		sh_px = 2'(info.sh_l) + 2'(info.sh_b);
		wsum  = 10'(upper_left >> sh_ul) + 10'(up >> sh_up)
		      + 10'(left >> sh_lf) + 10'(px >> sh_px);
		q_two = div9({wsum, 2'b00});
	end

	// Box modes: add this row's group sum to the column sum of the band.
	always_comb begin
		block_sum = info.band0 ? hsum : col_sum + hsum;
		q_three   = div9(block_sum);
		sum_wdata = block_sum;
	end

	// Select the output pixel by mode.
	always_comb begin
		res.emit = info.emit;
		res.eor  = info.eor;
		res.eof  = info.eof;
		case (info.mode)
			MODE_FULL:       res.pixel = px;
			MODE_TWO_THIRDS: res.pixel = q_two[7:0];
			MODE_HALF:       res.pixel = block_sum[9:2];
			MODE_THIRD:      res.pixel = q_three[7:0];
			default:         res.pixel = block_sum[11:4];
		endcase
	end

endmodule
